// ===== rtl/rae_pkg.sv =====
// Package for the request/acknowledge exchange master.
// Holds the command and link state codes and the result record type.
// No dependencies.
package rae_pkg;

    typedef enum logic [1:0] {
        CMD_APPEND = 2'd0,
        CMD_START  = 2'd1,
        CMD_ACK    = 2'd2,
        CMD_DONE   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_RESET_SLAVE   = 3'd0,
        ST_IDLE          = 3'd1,
        ST_AWAIT_ACK     = 3'd2,
        ST_AWAIT_XFER    = 3'd3,
        ST_AWAIT_RELEASE = 3'd4
    } link_state_t;

    localparam int unsigned SIZE_W  = 12;
    localparam int unsigned BYTES_W = 9;
    localparam int unsigned SEQ_W   = 32;

    typedef struct packed {
        logic               accepted;
        logic               rx_valid;
        logic               rx_ready_index;
        logic               req_level;
        logic               start_transfer;
        logic [1:0]         tx_send_index;
        logic               rx_target_index;
        logic [BYTES_W-1:0] payload_bytes;
        logic [SEQ_W-1:0]   message_number;
        logic               fault;
        logic [2:0]         link_state;
    } result_t;

endpackage

// ===== rtl/rae_ifs.sv =====
// Valid/ready channel interfaces for the exchange master: command input
// and result output. Depends on rae_pkg for field widths.
interface rae_cmd_if
    import rae_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        cmd;
    logic [SIZE_W-1:0] msg_size;

    modport source (output valid, output cmd, output msg_size, input ready);
    modport sink   (input valid, input cmd, input msg_size, output ready);
endinterface

interface rae_res_if
    import rae_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               accepted;
    logic               rx_valid;
    logic               rx_ready_index;
    logic               req_level;
    logic               start_transfer;
    logic [1:0]         tx_send_index;
    logic               rx_target_index;
    logic [BYTES_W-1:0] payload_bytes;
    logic [SEQ_W-1:0]   message_number;
    logic               fault;
    logic [2:0]         link_state;

    modport source (
        output valid, output accepted, output rx_valid, output rx_ready_index,
        output req_level, output start_transfer, output tx_send_index,
        output rx_target_index, output payload_bytes, output message_number,
        output fault, output link_state, input ready
    );
    modport sink (
        input valid, input accepted, input rx_valid, input rx_ready_index,
        input req_level, input start_transfer, input tx_send_index,
        input rx_target_index, input payload_bytes, input message_number,
        input fault, input link_state, output ready
    );
endinterface

// ===== rtl/req_ack_exchange_master_top.sv =====
// Top level of the request/acknowledge exchange master: command register,
// update core and result register. Depends on rae_pkg, rae_ifs, rae_core.
//
// Usage:
//   cmd_in  carries one command per transfer: append message (with msg_size),
//           start exchange, ACK edge or transfer complete.
//   res_out carries one result per command, in order: append verdict,
//           receive buffer handout, launch details (transmit and receive
//           buffer indices, payload byte count, message number), the REQ
//           level, a fault flag and the link state after the command.
//   Path: a command transfer loads the command register, and the result
//   register loads from it while res_out is not held; res_out.valid rises
//   once the result register holds the result.
//   Throughput: one command per cycle unless res_out is held; the state
//   update is a single pass of logic between the command and result registers.
//   Reset: the link starts in the slave reset state, the receive processing
//   index is 0, the transmit indices are send 0, waiting 1, filling 2, the
//   message counter and the pending byte count are 0.
//   Stall: while res_out is held, the result register holds, the command
//   register fills, and cmd_in.ready drops once both are full; no command
//   is lost or applied twice.
module req_ack_exchange_master_top
    import rae_pkg::*;
#(
    parameter int unsigned PAYLOAD_BYTES = 256
)
(
    input  logic     clk,
    input  logic     rst_n,
    rae_cmd_if.sink  cmd_in,
    rae_res_if.source res_out
);

    logic              stage_valid_reg, stage_valid_next;
    logic [1:0]        stage_cmd_reg;
    logic [SIZE_W-1:0] stage_size_reg;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg;
    result_t           result;
    logic              advance;
    logic              in_fire;
    logic              fire;

    assign advance      = !out_valid_reg || res_out.ready;
    assign cmd_in.ready = !stage_valid_reg || advance;
    assign in_fire      = cmd_in.valid && cmd_in.ready;
    assign fire         = stage_valid_reg && advance;

    assign stage_valid_next = in_fire ? 1'b1 : (advance ? 1'b0 : stage_valid_reg);
    assign out_valid_next   = advance ? stage_valid_reg : out_valid_reg;

    rae_core #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (fire),
        .cmd      (stage_cmd_reg),
        .msg_size (stage_size_reg),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            stage_cmd_reg  <= cmd_in.cmd;
            stage_size_reg <= cmd_in.msg_size;
        end
        if (fire)
            out_reg <= result;
    end

    assign res_out.valid           = out_valid_reg;
    assign res_out.accepted        = out_reg.accepted;
    assign res_out.rx_valid        = out_reg.rx_valid;
    assign res_out.rx_ready_index  = out_reg.rx_ready_index;
    assign res_out.req_level       = out_reg.req_level;
    assign res_out.start_transfer  = out_reg.start_transfer;
    assign res_out.tx_send_index   = out_reg.tx_send_index;
    assign res_out.rx_target_index = out_reg.rx_target_index;
    assign res_out.payload_bytes   = out_reg.payload_bytes;
    assign res_out.message_number  = out_reg.message_number;
    assign res_out.fault           = out_reg.fault;
    assign res_out.link_state      = out_reg.link_state;

endmodule

// ===== rtl/rae_core.sv =====
// Link state, buffer index rotation, payload count and message counter of
// the exchange master, with the per-command update logic.
// Depends on rae_pkg.
module rae_core
    import rae_pkg::*;
#(
    parameter int unsigned PAYLOAD_BYTES = 256
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              fire,
    input  logic [1:0]        cmd,
    input  logic [SIZE_W-1:0] msg_size,
    output result_t           result
);

    localparam int unsigned PEND_W = $clog2(PAYLOAD_BYTES + 1);
    localparam int unsigned SUM_W  = SIZE_W + 1;

    link_state_t       state_reg, state_next;
    logic              rx_proc_reg, rx_proc_next;
    logic [1:0]        tx_send_reg, tx_send_next;
    logic [1:0]        tx_wait_reg, tx_wait_next;
    logic [1:0]        tx_fill_reg, tx_fill_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;
    logic [PEND_W-1:0] pend_reg, pend_next;

    logic [SUM_W-1:0]  pend_ext;
    logic [SUM_W-1:0]  sum;
    logic [SEQ_W-1:0]  seq_inc;

    assign pend_ext = {{(SUM_W - PEND_W){1'b0}}, pend_reg};
    assign sum      = pend_ext + {1'b0, msg_size};
    assign seq_inc  = seq_reg + 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        rx_proc_next = rx_proc_reg;
        tx_send_next = tx_send_reg;
        tx_wait_next = tx_wait_reg;
        tx_fill_next = tx_fill_reg;
        seq_next     = seq_reg;
        pend_next    = pend_reg;
        result       = '0;

        unique case (cmd_t'(cmd))
            CMD_APPEND:
            begin
                if (sum <= SUM_W'(PAYLOAD_BYTES))
                begin
                    pend_next       = sum[PEND_W-1:0];
                    result.accepted = 1'b1;
                end
            end
            CMD_START:
            begin
                if (state_reg == ST_RESET_SLAVE)
                begin
                    result.rx_valid       = 1'b1;
                    result.rx_ready_index = rx_proc_reg;
                end
                else if (state_reg == ST_IDLE)
                begin
                    rx_proc_next          = ~rx_proc_reg;
                    state_next            = ST_AWAIT_ACK;
                    result.rx_valid       = 1'b1;
                    result.rx_ready_index = ~rx_proc_reg;
                end
            end
            CMD_ACK:
            begin
                unique case (state_reg)
                    ST_IDLE:
                    begin
                    end
                    ST_RESET_SLAVE, ST_AWAIT_RELEASE:
                    begin
                        state_next = ST_IDLE;
                    end
                    ST_AWAIT_ACK:
                    begin
                        state_next             = ST_AWAIT_XFER;
                        result.start_transfer  = 1'b1;
                        result.tx_send_index   = tx_send_reg;
                        result.rx_target_index = ~rx_proc_reg;
                        result.payload_bytes   = pend_ext[BYTES_W-1:0];
                        result.message_number  = seq_inc;
                        pend_next              = '0;
                        seq_next               = seq_inc;
                        tx_send_next           = tx_wait_reg;
                        tx_wait_next           = tx_fill_reg;
                        tx_fill_next           = tx_send_reg;
                    end
                    default:
                    begin
                        result.fault = 1'b1;
                    end
                endcase
            end
            CMD_DONE:
            begin
                if (state_reg == ST_AWAIT_XFER)
                    state_next = ST_AWAIT_RELEASE;
                else
                    result.fault = 1'b1;
            end
            default:
            begin
            end
        endcase

        result.req_level  = (state_next == ST_AWAIT_ACK) || (state_next == ST_AWAIT_XFER);
        result.link_state = state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_RESET_SLAVE;
            rx_proc_reg <= 1'b0;
            tx_send_reg <= 2'd0;
            tx_wait_reg <= 2'd1;
            tx_fill_reg <= 2'd2;
            seq_reg     <= '0;
            pend_reg    <= '0;
        end
        else if (fire)
        begin
            state_reg   <= state_next;
            rx_proc_reg <= rx_proc_next;
            tx_send_reg <= tx_send_next;
            tx_wait_reg <= tx_wait_next;
            tx_fill_reg <= tx_fill_next;
            seq_reg     <= seq_next;
            pend_reg    <= pend_next;
        end
    end

endmodule
